### sv/gcm_pkg.sv
// gcm_pkg: widths, register indexes and the configuration struct shared by
// the grid cell mapper modules. No dependencies.
package gcm_pkg;

   // coordinate and size widths
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS  = COORD_BITS + 1;
   localparam int CNT_BITS   = 7;
   localparam int MAX_GRID   = 64;
   localparam int CELL_BITS  = 20;

   // shared divider widths
   localparam int DIV_BITS     = SIZE_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);

   // multiplier widths: signed operands one bit wider than a size
   localparam int MUL_BITS  = SIZE_BITS + 1;
   localparam int PROD_BITS = 2 * MUL_BITS;
   localparam int ACC_BITS  = 2 * SIZE_BITS + 1;

   // configuration port
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = SIZE_BITS;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_REGION_LEFT   = 3'd0,
      CSR_REGION_TOP    = 3'd1,
      CSR_REGION_WIDTH  = 3'd2,
      CSR_REGION_HEIGHT = 3'd3,
      CSR_GRID_ROWS     = 3'd4,
      CSR_GRID_COLS     = 3'd5,
      CSR_JUMP_LIMIT    = 3'd6
   } csr_index_type;

   // register reset values
   localparam logic [SIZE_BITS-1:0] RESET_WIDTH  = SIZE_BITS'(640);
   localparam logic [SIZE_BITS-1:0] RESET_HEIGHT = SIZE_BITS'(480);
   localparam logic [CNT_BITS-1:0]  RESET_COUNT  = CNT_BITS'(1);
   localparam logic [SIZE_BITS-1:0] RESET_LIMIT  = SIZE_BITS'(50);

   // configuration as seen by the sequencer, grid counts already clamped
   typedef struct packed {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [SIZE_BITS-1:0]  width;
      logic [SIZE_BITS-1:0]  height;
      logic [CNT_BITS-1:0]   rows;
      logic [CNT_BITS-1:0]   cols;
      logic [SIZE_BITS-1:0]  limit;
   } cfg_type;

   // zero counts as one, anything above the grid limit saturates
   function automatic logic [CNT_BITS-1:0] clamp_count(input logic [CNT_BITS-1:0] v);
      logic [CNT_BITS-1:0] r;
      if (v == '0) begin
         r = CNT_BITS'(1);
      end else if (v > CNT_BITS'(MAX_GRID)) begin
         r = CNT_BITS'(MAX_GRID);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### sv/gcm_csr.sv
// gcm_csr: configuration registers of the grid cell mapper.
// Depends on gcm_pkg for widths, register indexes and cfg_type.
module gcm_csr
   import gcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   logic [COORD_BITS-1:0] left_ff;
   logic [COORD_BITS-1:0] top_ff;
   logic [SIZE_BITS-1:0]  width_ff;
   logic [SIZE_BITS-1:0]  height_ff;
   logic [CNT_BITS-1:0]   rows_ff;
   logic [CNT_BITS-1:0]   cols_ff;
   logic [SIZE_BITS-1:0]  limit_ff;

   // register writes, unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         top_ff    <= '0;
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         rows_ff   <= RESET_COUNT;
         cols_ff   <= RESET_COUNT;
         limit_ff  <= RESET_LIMIT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_REGION_LEFT:   left_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_TOP:    top_ff    <= csr_wdata[COORD_BITS-1:0];
            CSR_REGION_WIDTH:  width_ff  <= csr_wdata[SIZE_BITS-1:0];
            CSR_REGION_HEIGHT: height_ff <= csr_wdata[SIZE_BITS-1:0];
            CSR_GRID_ROWS:     rows_ff   <= csr_wdata[CNT_BITS-1:0];
            CSR_GRID_COLS:     cols_ff   <= csr_wdata[CNT_BITS-1:0];
            CSR_JUMP_LIMIT:    limit_ff  <= csr_wdata[SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // clamped view for the sequencer
   always_comb begin
      cfg.left   = left_ff;
      cfg.top    = top_ff;
      cfg.width  = width_ff;
      cfg.height = height_ff;
      cfg.rows   = clamp_count(rows_ff);
      cfg.cols   = clamp_count(cols_ff);
      cfg.limit  = limit_ff;
   end

endmodule

### sv/gcm_div.sv
// gcm_div: unsigned restoring divider, one quotient bit per cycle.
// Depends on gcm_pkg for DIV_BITS and DIV_CNT_BITS.
module gcm_div
   import gcm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0] divisor,
   output logic                done,
   output logic [DIV_BITS-1:0] quotient
);

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [DIV_BITS:0]       rem_ff;
   logic [DIV_BITS-1:0]     quo_ff;
   logic [DIV_BITS-1:0]     den_ff;

   logic [DIV_BITS:0]       trial;
   logic [DIV_BITS+1:0]     diff;
   logic                    fits;

   // one restoring step: shift in the next dividend bit, try to subtract
   always_comb begin
      trial = {rem_ff[DIV_BITS-1:0], quo_ff[DIV_BITS-1]};
      diff  = {1'b0, trial} - {2'b00, den_ff};
      fits  = !diff[DIV_BITS+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == DIV_CNT_BITS'(1));
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_BITS'(DIV_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DIV_BITS:0] : trial;
         quo_ff <= {quo_ff[DIV_BITS-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/grid_cell_mapper_with_jump_gate.sv
// Grid cell mapper with jump gate: top level, sequencer and shared multiplier.
// Depends on gcm_pkg, gcm_csr and gcm_div.
//
// Usage:
//   req_* carries one tracked point per item: req_tdata holds point_x and
//   point_y, req_tuser holds first_frame. rsp_* returns one item per point:
//   rsp_tdata holds the 20-bit signed cell number, rsp_tuser the accepted flag.
//   csr_* writes the seven configuration registers; write only while idle.
// Sequence:
//   an item runs through four divisions on one shared 13-step restoring
//   divider (cell width, cell height, column, row), then three squaring
//   steps and one cell step on a single multiplier. The block takes the
//   next item only after the result has moved to the output register.
// Reset:
//   registers return to their defaults, stored position and held cell clear.
// Stall:
//   a result waits in the output register; the block accepts the next item
//   meanwhile and holds its own new result until the receiver takes the last.
module grid_cell_mapper_with_jump_gate
   import gcm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // point_x [11:0], point_y [23:12]
   input  logic [23:0]              req_tdata,
   // first_frame [0]
   input  logic                     req_tuser,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // cell_number [19:0], zero [23:20]
   output logic [23:0]              rsp_tdata,
   // accepted [0]
   output logic                     rsp_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_LAUNCH,
      S_WAIT,
      S_SQ_DX,
      S_SQ_DY,
      S_SQ_LIM,
      S_CELL,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      DIV_CELL_W,
      DIV_CELL_H,
      DIV_COL,
      DIV_ROW
   } div_sel_type;

   cfg_type cfg;

   state_type               state_ff;
   div_sel_type             sel_ff;
   logic [COORD_BITS-1:0]   px_ff;
   logic [COORD_BITS-1:0]   py_ff;
   logic [COORD_BITS-1:0]   last_x_ff;
   logic [COORD_BITS-1:0]   last_y_ff;
   logic [SIZE_BITS-1:0]    cell_w_ff;
   logic [SIZE_BITS-1:0]    cell_h_ff;
   logic [MUL_BITS-1:0]     col_ff;
   logic [MUL_BITS-1:0]     row_ff;
   logic [ACC_BITS-1:0]     dist_ff;
   logic [ACC_BITS-1:0]     lim2_ff;
   logic [CELL_BITS-1:0]    held_ff;
   logic                    ok_ff;
   logic                    rsp_valid_ff;
   logic [CELL_BITS-1:0]    rsp_cell_ff;
   logic                    rsp_ok_ff;

   logic                    div_start;
   logic                    div_done;
   logic [DIV_BITS-1:0]     div_num;
   logic [DIV_BITS-1:0]     div_den;
   logic [DIV_BITS-1:0]     div_quo;

   logic [SIZE_BITS-1:0]    diff_x;
   logic [SIZE_BITS-1:0]    diff_y;
   logic [SIZE_BITS-1:0]    mag_x;
   logic [SIZE_BITS-1:0]    mag_y;
   logic [SIZE_BITS-1:0]    dx;
   logic [SIZE_BITS-1:0]    dy;
   logic                    div_neg;
   logic                    div_zero;
   logic [MUL_BITS-1:0]     quo_signed;

   logic signed [MUL_BITS-1:0]  mul_a;
   logic signed [MUL_BITS-1:0]  mul_b;
   logic signed [PROD_BITS-1:0] mul_p;
   logic [PROD_BITS-1:0]        cell_sum;
   logic                        jump_ok;

   gcm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // offsets from the region corner and jumps from the stored position
   always_comb begin
      diff_x = {1'b0, px_ff} - {1'b0, cfg.left};
      diff_y = {1'b0, py_ff} - {1'b0, cfg.top};
      mag_x  = diff_x[SIZE_BITS-1] ? (SIZE_BITS'(0) - diff_x) : diff_x;
      mag_y  = diff_y[SIZE_BITS-1] ? (SIZE_BITS'(0) - diff_y) : diff_y;
      dx     = {1'b0, px_ff} - {1'b0, last_x_ff};
      dy     = {1'b0, py_ff} - {1'b0, last_y_ff};
   end

   // divider operand select
   always_comb begin
      div_start = (state_ff == S_LAUNCH);
      div_num   = '0;
      div_den   = '0;
      div_neg   = 1'b0;
      div_zero  = 1'b0;
      case (sel_ff)
         DIV_CELL_W: begin
            div_num = cfg.width;
            div_den = DIV_BITS'(cfg.cols);
         end
         DIV_CELL_H: begin
            div_num = cfg.height;
            div_den = DIV_BITS'(cfg.rows);
         end
         DIV_COL: begin
            div_num  = mag_x;
            div_den  = cell_w_ff;
            div_neg  = diff_x[SIZE_BITS-1];
            div_zero = (cell_w_ff == '0);
         end
         DIV_ROW: begin
            div_num  = mag_y;
            div_den  = cell_h_ff;
            div_neg  = diff_y[SIZE_BITS-1];
            div_zero = (cell_h_ff == '0);
         end
         default: ;
      endcase
      // truncation toward zero: divide magnitudes, then restore the sign
      if (div_zero) begin
         quo_signed = '0;
      end else if (div_neg) begin
         quo_signed = MUL_BITS'(0) - {1'b0, div_quo};
      end else begin
         quo_signed = {1'b0, div_quo};
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_SQ_DX: begin
            mul_a = {dx[SIZE_BITS-1], dx};
            mul_b = {dx[SIZE_BITS-1], dx};
         end
         S_SQ_DY: begin
            mul_a = {dy[SIZE_BITS-1], dy};
            mul_b = {dy[SIZE_BITS-1], dy};
         end
         S_SQ_LIM: begin
            mul_a = {1'b0, cfg.limit};
            mul_b = {1'b0, cfg.limit};
         end
         S_CELL: begin
            mul_a = MUL_BITS'(cfg.cols);
            mul_b = row_ff;
         end
         default: ;
      endcase
      mul_p    = mul_a * mul_b;
      cell_sum = PROD_BITS'(mul_p) + {{(PROD_BITS-MUL_BITS){col_ff[MUL_BITS-1]}}, col_ff}
                 + PROD_BITS'(1);
      jump_ok  = (dist_ff < lim2_ff);
   end

   // sequencer and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= DIV_CELL_W;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         held_ff      <= '0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  // a first frame starts with zero jump
                  if (req_tuser) begin
                     last_x_ff <= req_tdata[COORD_BITS-1:0];
                     last_y_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
                  end
                  sel_ff   <= DIV_CELL_W;
                  state_ff <= S_LAUNCH;
               end
            end
            S_LAUNCH: begin
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (div_done) begin
                  if (sel_ff == DIV_ROW) begin
                     state_ff <= S_SQ_DX;
                  end else begin
                     sel_ff   <= div_sel_type'(sel_ff + 2'd1);
                     state_ff <= S_LAUNCH;
                  end
               end
            end
            S_SQ_DX: begin
               state_ff <= S_SQ_DY;
            end
            S_SQ_DY: begin
               state_ff <= S_SQ_LIM;
            end
            S_SQ_LIM: begin
               state_ff <= S_CELL;
            end
            S_CELL: begin
               ok_ff <= jump_ok;
               if (jump_ok) begin
                  held_ff <= cell_sum[CELL_BITS-1:0];
               end
               last_x_ff <= px_ff;
               last_y_ff <= py_ff;
               state_ff  <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         px_ff <= req_tdata[COORD_BITS-1:0];
         py_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
      end
      // division results
      if (state_ff == S_WAIT && div_done) begin
         case (sel_ff)
            DIV_CELL_W: cell_w_ff <= div_quo;
            DIV_CELL_H: cell_h_ff <= div_quo;
            DIV_COL:    col_ff    <= quo_signed;
            DIV_ROW:    row_ff    <= quo_signed;
            default: ;
         endcase
      end
      // squared jump and squared limit
      case (state_ff)
         S_SQ_DX:  dist_ff <= mul_p[ACC_BITS-1:0];
         S_SQ_DY:  dist_ff <= dist_ff + mul_p[ACC_BITS-1:0];
         S_SQ_LIM: lim2_ff <= mul_p[ACC_BITS-1:0];
         default: ;
      endcase
      // result register
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp_tready)) begin
         rsp_cell_ff <= held_ff;
         rsp_ok_ff   <= ok_ff;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(24-CELL_BITS){1'b0}}, rsp_cell_ff};
   assign rsp_tuser  = rsp_ok_ff;

endmodule

### dv/tb_grid_cell_mapper_with_jump_gate.sv
// tb_grid_cell_mapper_with_jump_gate: self-checking testbench for the grid cell mapper,
// predicts the cell number and jump decision of every tracked point and checks each result.
// Depends on gcm_pkg and grid_cell_mapper_with_jump_gate.
module tb_grid_cell_mapper_with_jump_gate;
   import gcm_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1500000;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int COORD_MAX = (1 << COORD_BITS) - 1;

   // one result item as the mapper should return it
   typedef struct packed {
      logic [CELL_BITS-1:0] cell_no;
      logic                 accepted;
   } cell_result_type;

   // full register set for one phase of the run
   typedef struct {
      logic [COORD_BITS-1:0] left;
      logic [COORD_BITS-1:0] top;
      logic [SIZE_BITS-1:0]  width;
      logic [SIZE_BITS-1:0]  height;
      logic [CNT_BITS-1:0]   rows;
      logic [CNT_BITS-1:0]   cols;
      logic [SIZE_BITS-1:0]  limit;
   } grid_setup_type;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_COIN,
      STALL_PATTERN,
      STALL_RARE
   } stall_mode_type;

   // tracks the mapper state and the queue of cells still to come
   class cell_tracker;
      logic [COORD_BITS-1:0] left, top, last_x, last_y;
      logic [SIZE_BITS-1:0]  width, height, limit;
      logic [CNT_BITS-1:0]   rows, cols;
      logic [CELL_BITS-1:0]  held_cell;
      cell_result_type       expected_cells[$];
      int unsigned           errors;

      function new();
         left = '0;
         top = '0;
         width = RESET_WIDTH;
         height = RESET_HEIGHT;
         rows = RESET_COUNT;
         cols = RESET_COUNT;
         limit = RESET_LIMIT;
         last_x = '0;
         last_y = '0;
         held_cell = '0;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
         case (idx)
            CSR_REGION_LEFT:   left = v[COORD_BITS-1:0];
            CSR_REGION_TOP:    top = v[COORD_BITS-1:0];
            CSR_REGION_WIDTH:  width = v[SIZE_BITS-1:0];
            CSR_REGION_HEIGHT: height = v[SIZE_BITS-1:0];
            CSR_GRID_ROWS:     rows = v[CNT_BITS-1:0];
            CSR_GRID_COLS:     cols = v[CNT_BITS-1:0];
            CSR_JUMP_LIMIT:    limit = v[SIZE_BITS-1:0];
            default: ;
         endcase
      endfunction

      // zero counts as one, large counts saturate at the grid maximum
      function longint count_used(logic [CNT_BITS-1:0] v);
         if (v == '0) return longint'(1);
         if (v > MAX_GRID) return longint'(MAX_GRID);
         return longint'(v);
      endfunction

      // compute the cell for an accepted point and update the stored position
      function void note_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                               logic first);
         longint n_rows, n_cols, cell_w, cell_h, row, col, cell_no;
         longint px_s, py_s, lx, ly, left_s, top_s, lim_s;
         logic near;
         n_rows = count_used(rows);
         n_cols = count_used(cols);
         cell_w = longint'(width);
         cell_h = longint'(height);
         cell_w = cell_w / n_cols;
         cell_h = cell_h / n_rows;
         if (first) begin
            last_x = px;
            last_y = py;
         end
         px_s = longint'(px);
         py_s = longint'(py);
         lx = longint'(last_x);
         ly = longint'(last_y);
         left_s = longint'(left);
         top_s = longint'(top);
         lim_s = longint'(limit);
         near = ((px_s - lx) * (px_s - lx) + (py_s - ly) * (py_s - ly)) < lim_s * lim_s;
         // signed quotients truncate toward zero, a zero cell size gives zero
         row = (cell_h > 0) ? (py_s - top_s) / cell_h : 0;
         col = (cell_w > 0) ? (px_s - left_s) / cell_w : 0;
         cell_no = 1 + n_cols * row + col;
         if (near) held_cell = cell_no[CELL_BITS-1:0];
         last_x = px;
         last_y = py;
         expected_cells.push_back('{cell_no: held_cell, accepted: near});
      endfunction

      task report_mismatch(string what);
         if (errors < 40) $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_cell(logic [CELL_BITS-1:0] got_cell, logic got_accepted);
         cell_result_type want;
         if (expected_cells.size() == 0) begin
            report_mismatch($sformatf("unexpected cell %0d", $signed(got_cell)));
         end else begin
            want = expected_cells.pop_front();
            if (got_cell !== want.cell_no)
               report_mismatch($sformatf("cell number %0d, want %0d",
                                         $signed(got_cell), $signed(want.cell_no)));
            if (got_accepted !== want.accepted)
               report_mismatch($sformatf("accepted %b, want %b", got_accepted,
                                         want.accepted));
         end
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   // point_x [11:0], point_y [23:12]
   logic [23:0]              req_tdata = '0;
   // first_frame [0]
   logic                     req_tuser = 1'b0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // cell_number [19:0], zero [23:20]
   logic [23:0]              rsp_tdata;
   // accepted [0]
   logic                     rsp_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   cell_tracker           tracker = new();
   int unsigned           cycle_count = 0;
   int unsigned           burst_left = 0;
   bit                    steady_send = 1'b0;
   bit                    hold_request = 1'b0;
   logic [COORD_BITS-1:0] prev_x = '0;
   logic [COORD_BITS-1:0] prev_y = '0;

   grid_cell_mapper_with_jump_gate i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side: check each item, stall in changing modes, long hold on request
   initial begin : rsp_side
      int unsigned    hold_left;
      int unsigned    mode_left;
      int unsigned    phase;
      stall_mode_type mode;
      hold_left = 0;
      mode_left = 0;
      phase = 0;
      mode = STALL_NONE;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
            tracker.check_cell(rsp_tdata[CELL_BITS-1:0], rsp_tuser);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            phase++;
            case (mode)
               STALL_NONE:    rsp_tready <= 1'b1;
               STALL_COIN:    rsp_tready <= ($urandom_range(0, 1) == 1);
               STALL_PATTERN: rsp_tready <= ((phase % 7) >= 3);
               default:       rsp_tready <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // offer one point and wait for it to be taken; bursts end in a random gap
   task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                             logic first);
      int unsigned gap;
      if (!req_tvalid) req_tvalid <= 1'b1;
      req_tdata <= {py, px};
      req_tuser <= first;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_point(px, py, first);
      prev_x = px;
      prev_y = py;
      if (!steady_send) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 5);
            gap = $urandom_range(1, 90);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every expected cell has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (tracker.expected_cells.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] v);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      tracker.set_reg(idx, v);
   endtask

   task automatic apply_setup(grid_setup_type s);
      drain();
      write_csr(CSR_REGION_LEFT, CSR_DATA_BITS'(s.left));
      write_csr(CSR_REGION_TOP, CSR_DATA_BITS'(s.top));
      write_csr(CSR_REGION_WIDTH, s.width);
      write_csr(CSR_REGION_HEIGHT, s.height);
      write_csr(CSR_GRID_ROWS, CSR_DATA_BITS'(s.rows));
      write_csr(CSR_GRID_COLS, CSR_DATA_BITS'(s.cols));
      write_csr(CSR_JUMP_LIMIT, s.limit);
      csr_we <= 1'b0;
   endtask

   // mostly short moves around the limit, some boundary steps, some random jumps
   task automatic send_random_points(int unsigned count);
      int          nx, ny, reach;
      int unsigned kind;
      logic        first;
      repeat (count) begin
         kind = $urandom_range(0, 19);
         first = 1'b0;
         nx = int'(prev_x);
         ny = int'(prev_y);
         reach = (tracker.limit >= COORD_MAX) ? COORD_MAX : int'(tracker.limit) + 2;
         if (kind < 4) begin
            nx = $urandom_range(0, COORD_MAX);
            ny = $urandom_range(0, COORD_MAX);
            first = (kind < 2);
         end else if (kind < 7) begin
            // step along one axis exactly at or one pixel inside the limit
            reach = int'(tracker.limit) - int'($urandom_range(0, 1));
            if ($urandom_range(0, 1) == 1) reach = -reach;
            if ($urandom_range(0, 1) == 1) nx += reach;
            else ny += reach;
         end else begin
            nx += int'($urandom_range(0, 2 * reach)) - reach;
            ny += int'($urandom_range(0, 2 * reach)) - reach;
            first = (kind == 7);
         end
         if (nx < 0) nx = 0;
         if (nx > COORD_MAX) nx = COORD_MAX;
         if (ny < 0) ny = 0;
         if (ny > COORD_MAX) ny = COORD_MAX;
         send_point(nx[COORD_BITS-1:0], ny[COORD_BITS-1:0], first);
      end
   endtask

   initial begin : stimulus
      grid_setup_type setup;
      int unsigned    lim_cap;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset state: stored position at the origin, default region and limit
      send_point(12'd0, 12'd0, 1'b0);
      send_point(12'd4095, 12'd4095, 1'b0);
      send_point(12'd320, 12'd240, 1'b1);

      // 4 x 8 grid of 80 x 120 cells at (100, 50), limit 50
      setup = '{left: 12'd100, top: 12'd50, width: 13'd640, height: 13'd480,
                rows: 7'd4, cols: 7'd8, limit: 13'd50};
      apply_setup(setup);
      send_point(12'd100, 12'd50, 1'b1);
      send_point(12'd139, 12'd79, 1'b0);
      send_point(12'd179, 12'd79, 1'b0);
      send_point(12'd180, 12'd79, 1'b0);
      send_point(12'd230, 12'd79, 1'b0);   // jump equal to the limit is held
      send_point(12'd99, 12'd49, 1'b1);    // just outside, quotients round to zero
      send_point(12'd0, 12'd0, 1'b0);
      send_point(12'd0, 12'd0, 1'b1);      // negative column
      send_point(12'd4095, 12'd4095, 1'b1);
      send_point(12'd4095, 12'd0, 1'b0);
      send_point(12'd4095, 12'd0, 1'b1);
      send_point(12'd4094, 12'd1, 1'b0);
      send_point(12'hAAA, 12'h555, 1'b1);
      send_point(12'h555, 12'hAAA, 1'b0);

      // zero limit: even a first frame is rejected
      setup.limit = 13'd0;
      apply_setup(setup);
      send_point(12'd500, 12'd300, 1'b1);
      send_point(12'd500, 12'd300, 1'b0);

      // widest limit: full-axis jump passes, full diagonal does not
      setup.limit = 13'd4096;
      apply_setup(setup);
      send_point(12'd0, 12'd0, 1'b1);
      send_point(12'd4095, 12'd4095, 1'b0);
      send_point(12'd4095, 12'd0, 1'b0);
      send_point(12'd0, 12'd0, 1'b0);

      // largest region and finest grid; receiver holds off while points keep coming
      setup = '{left: 12'd0, top: 12'd0, width: 13'd4096, height: 13'd4096,
                rows: 7'd64, cols: 7'd64, limit: 13'd4096};
      apply_setup(setup);
      hold_request = 1'b1;
      steady_send = 1'b1;
      send_random_points(10);
      steady_send = 1'b0;
      send_random_points(140);

      // one-pixel region at the far corner, nothing ever accepted
      setup = '{left: 12'd4095, top: 12'd4095, width: 13'd1, height: 13'd1,
                rows: 7'd1, cols: 7'd1, limit: 13'd0};
      apply_setup(setup);
      send_random_points(100);

      // zero row count and oversize column count
      setup = '{left: 12'd0, top: 12'd0, width: 13'd4096, height: 13'd4096,
                rows: 7'd0, cols: 7'd127, limit: 13'd300};
      apply_setup(setup);
      send_random_points(100);

      // more columns than pixels: zero cell width
      setup = '{left: 12'd0, top: 12'd0, width: 13'd5, height: 13'd4096,
                rows: 7'd64, cols: 7'd64, limit: 13'd100};
      apply_setup(setup);
      send_random_points(100);

      // random legal settings
      repeat (6) begin
         setup.width = SIZE_BITS'($urandom_range(1, 4096));
         setup.height = SIZE_BITS'($urandom_range(1, 4096));
         lim_cap = (int'(setup.width) < MAX_GRID) ? int'(setup.width) : MAX_GRID;
         setup.cols = CNT_BITS'($urandom_range(1, lim_cap));
         lim_cap = (int'(setup.height) < MAX_GRID) ? int'(setup.height) : MAX_GRID;
         setup.rows = CNT_BITS'($urandom_range(1, lim_cap));
         setup.left = COORD_BITS'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 4095)
                                                              : $urandom_range(0, 255));
         setup.top = COORD_BITS'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 4095)
                                                             : $urandom_range(0, 255));
         setup.limit = SIZE_BITS'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 4096)
                                                              : $urandom_range(1, 200));
         apply_setup(setup);
         if ($urandom_range(0, 2) == 0) begin
            hold_request = 1'b1;
            steady_send = 1'b1;
            send_random_points(8);
            steady_send = 1'b0;
         end
         send_random_points(150);
      end

      drain();
      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
